[hdl/rpds_pkg.sv]
// Package for the render pass dependency scheduler.
// Command and status codes shared by the top level, output buffer and testbench. No dependencies.
package rpds_pkg;
  localparam int CMD_W = 3;
  localparam int STAT_W = 4;
  localparam int ID_W = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD_RES = 3'd0,
    CMD_ADD_PASS = 3'd1,
    CMD_ADD_READ = 3'd2,
    CMD_ADD_WRITE = 3'd3,
    CMD_SCHEDULE = 3'd4,
    CMD_CLEAR = 3'd5
  } cmd_t;

  localparam logic [STAT_W-1:0] ST_OK = 4'd0;
  localparam logic [STAT_W-1:0] ST_REJECT = 4'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 4'd2;
  localparam logic [STAT_W-1:0] ST_BOUNDS = 4'd3;
  localparam logic [STAT_W-1:0] ST_CLR_READS = 4'd4;
  localparam logic [STAT_W-1:0] ST_CLR_NOWRITE = 4'd5;
  localparam logic [STAT_W-1:0] ST_RB_NOREAD = 4'd6;
  localparam logic [STAT_W-1:0] ST_RB_WRITES = 4'd7;
  localparam logic [STAT_W-1:0] ST_NEG_MIP = 4'd8;
  localparam logic [STAT_W-1:0] ST_ORD_MISSING = 4'd9;
  localparam logic [STAT_W-1:0] ST_MULTI_WRITER = 4'd10;
  localparam logic [STAT_W-1:0] ST_CYCLE = 4'd11;

  localparam logic [2:0] KIND_CLEAR = 3'd0;
  localparam logic [2:0] KIND_READBACK = 3'd1;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0] id;
    logic last;
  } result_t;
endpackage

[hdl/rpds_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module rpds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[hdl/rpds_out_buf.sv]
// Output register stage for result transactions.
// Depends on rpds_pkg.
module rpds_out_buf (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  rpds_pkg::result_t push_data,
  output logic full,
  input  logic out_ready,
  output logic out_valid,
  output rpds_pkg::result_t out_data
);
  import rpds_pkg::*;

  logic valid_r;
  result_t data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
    if (push) data_r <= push_data;
  end

  assign full = valid_r && !out_ready;
  assign out_valid = valid_r;
  assign out_data = data_r;

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("result overwritten");
`endif
endmodule

[hdl/render_pass_dependency_scheduler_top.sv]
// Render pass dependency scheduler top level; depends on rpds_pkg, rpds_ram, rpds_out_buf.
// One transaction in flight. Add resource, add pass, clear and unknown commands go from
// acceptance to S_OUT, which pushes the result. Add read/write first searches the pass's
// read and write lists. Schedule validates, then repeats a pick of the lowest ready pass
// and a walk over every read list, then emits one result per scheduled pass. Output stalls
// hold the block. Synchronous active-low reset clears counts and control state only.
module render_pass_dependency_scheduler_top #(
  parameter int MAX_RESOURCES = 64,
  parameter int MAX_PASSES = 32,
  parameter int MAX_REFS = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic [2:0] in_cmd,
  input  logic [5:0] in_pass_id,
  input  logic [6:0] in_resource_id,
  input  logic signed [15:0] in_width,
  input  logic signed [15:0] in_height,
  input  logic [2:0] in_pass_type,
  input  logic signed [7:0] in_mip,
  output logic out_valid,
  input  logic out_ready,
  output logic [3:0] out_status,
  output logic [6:0] out_id,
  output logic out_last
);
  import rpds_pkg::*;

  localparam int RW = $clog2(MAX_RESOURCES);
  localparam int PW = $clog2(MAX_PASSES);
  localparam int FW = $clog2(MAX_REFS) > 0 ? $clog2(MAX_REFS) : 1;
  localparam int REFD = MAX_PASSES * MAX_REFS * 2;
  localparam int AW = $clog2(REFD);
  localparam int CW = $clog2(MAX_REFS + 1);
  localparam int RCW = $clog2(MAX_RESOURCES + 1);
  localparam int PCW = $clog2(MAX_PASSES + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_REF_RD, S_REF_CHK, S_OUT,
    S_V_RES, S_V_RES_CHK, S_V_PASS, S_V_WR, S_V_WR_CHK,
    S_P_INIT, S_P_RD, S_P_CHK,
    S_K_FIND, S_K_UPD, S_K_URD, S_K_UWO, S_K_UCHK,
    S_EMIT_RD, S_EMIT
  } state_t;

  state_t state_r;
  logic [RCW-1:0] rcnt_r;
  logic [RCW-1:0] r_r;
  logic [PCW-1:0] pcnt_r;
  logic [PCW-1:0] pp_r;
  logic [PCW-1:0] emitted_r;
  logic [PCW-1:0] ei_r;
  logic [CW-1:0] rdc_r [MAX_PASSES];
  logic [CW-1:0] wrc_r [MAX_PASSES];
  logic [2:0] kind_r [MAX_PASSES];
  logic neg_r [MAX_PASSES];
  logic [CW-1:0] pend_r [MAX_PASSES];
  logic [MAX_PASSES-1:0] done_r;
  logic [MAX_RESOURCES-1:0] wvalid_r;

  logic [2:0] cmd_r;
  logic [6:0] rid_r;
  logic [CW-1:0] i_r;
  logic side_r;
  logic [PW-1:0] cur_r;
  logic [STAT_W-1:0] st_r;
  logic [ID_W-1:0] id_r;

  logic ram_we;
  logic [AW-1:0] ram_wa, ram_ra;
  logic [6:0] ram_wd, ram_rd;
  logic wo_we;
  logic [RW-1:0] wo_wa, wo_ra;
  logic [PW-1:0] wo_wd, wo_rd;
  logic rok_we;
  logic [RW-1:0] rok_wa, rok_ra;
  logic rok_wd, rok_rd;
  logic ob_we;
  logic [PW-1:0] ob_wa, ob_ra;
  logic [PW-1:0] ob_wd, ob_rd;

  logic ob_push, ob_full;
  result_t push_d, out_d;

  rpds_ram #(.WIDTH(7), .DEPTH(REFD)) u_refs (
    .clk, .we(ram_we), .waddr(ram_wa), .wdata(ram_wd), .raddr(ram_ra), .rdata(ram_rd));
  rpds_ram #(.WIDTH(PW), .DEPTH(MAX_RESOURCES)) u_writer (
    .clk, .we(wo_we), .waddr(wo_wa), .wdata(wo_wd), .raddr(wo_ra), .rdata(wo_rd));
  rpds_ram #(.WIDTH(1), .DEPTH(MAX_RESOURCES)) u_resok (
    .clk, .we(rok_we), .waddr(rok_wa), .wdata(rok_wd), .raddr(rok_ra), .rdata(rok_rd));
  rpds_ram #(.WIDTH(PW), .DEPTH(MAX_PASSES)) u_order (
    .clk, .we(ob_we), .waddr(ob_wa), .wdata(ob_wd), .raddr(ob_ra), .rdata(ob_rd));

  rpds_out_buf u_obuf (
    .clk, .rst_n, .push(ob_push), .push_data(push_d), .full(ob_full),
    .out_ready, .out_valid, .out_data(out_d));

  assign out_status = out_d.status;
  assign out_id = out_d.id;
  assign out_last = out_d.last;
  assign in_ready = (state_r == S_IDLE);

  function automatic logic [AW-1:0] ref_addr(logic [PW-1:0] p, logic s, logic [FW-1:0] i);
    return AW'((32'(p) * 2 + 32'(s)) * MAX_REFS + 32'(i));
  endfunction

  logic [PW-1:0] pidx;
  logic [CW-1:0] cur_cnt;
  logic [CW-1:0] tgt_cnt;
  logic [RW-1:0] ram_slot;
  assign pidx = pp_r[PW-1:0];
  assign cur_cnt = side_r ? wrc_r[pidx] : rdc_r[pidx];
  assign tgt_cnt = (cmd_r == CMD_ADD_WRITE) ? wrc_r[pidx] : rdc_r[pidx];
  assign ram_slot = RW'(ram_rd - 7'd1);

  logic [2:0] rk;
  logic [CW-1:0] nr, nw;
  logic [STAT_W-1:0] rule_st;
  always_comb begin
    rk = kind_r[pidx];
    nr = rdc_r[pidx];
    nw = wrc_r[pidx];
    rule_st = ST_OK;
    if (rk == KIND_CLEAR && nr != '0) rule_st = ST_CLR_READS;
    else if (rk == KIND_CLEAR && nw == '0) rule_st = ST_CLR_NOWRITE;
    else if (rk == KIND_READBACK && nr == '0) rule_st = ST_RB_NOREAD;
    else if (rk == KIND_READBACK && nw != '0) rule_st = ST_RB_WRITES;
    else if (neg_r[pidx]) rule_st = ST_NEG_MIP;
    else if (rk > KIND_READBACK && (nr == '0 || nw == '0)) rule_st = ST_ORD_MISSING;
  end

  logic [PW-1:0] find_idx;
  logic find_ok;
  always_comb begin
    find_idx = '0;
    find_ok = 1'b0;
    for (int k = MAX_PASSES - 1; k >= 0; k--) begin
      if (PCW'(k) < pcnt_r && !done_r[k] && pend_r[k] == '0) begin
        find_idx = PW'(k);
        find_ok = 1'b1;
      end
    end
  end

  always_comb begin
    ram_we = 1'b0;
    ram_wa = ref_addr(pidx, cmd_r == CMD_ADD_WRITE, tgt_cnt[FW-1:0]);
    ram_wd = rid_r;
    ram_ra = ref_addr(pidx, side_r, i_r[FW-1:0]);
    wo_we = 1'b0; wo_wa = ram_slot; wo_wd = pidx; wo_ra = ram_slot;
    rok_we = 1'b0; rok_wa = rcnt_r[RW-1:0]; rok_ra = r_r[RW-1:0];
    rok_wd = (in_width > 16'sd0) && (in_height > 16'sd0);
    ob_we = 1'b0; ob_wa = emitted_r[PW-1:0]; ob_wd = find_idx; ob_ra = ei_r[PW-1:0];
    ob_push = 1'b0;
    push_d = '{status: st_r, id: id_r, last: 1'b1};
    case (state_r)
      S_IDLE: rok_we = in_valid && in_cmd == CMD_ADD_RES && rcnt_r < RCW'(MAX_RESOURCES);
      S_REF_RD: ram_we = i_r >= cur_cnt && side_r && tgt_cnt < CW'(MAX_REFS);
      S_V_WR_CHK: wo_we = !wvalid_r[ram_slot];
      S_K_FIND: ob_we = find_ok;
      S_OUT: ob_push = !ob_full;
      S_EMIT: begin
        ob_push = !ob_full;
        push_d.status = ST_OK;
        push_d.id = ID_W'(ob_rd) + ID_W'(1);
        push_d.last = (ei_r + PCW'(1)) == pcnt_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rcnt_r <= '0;
      pcnt_r <= '0;
    end else begin
      case (state_r)
        S_IDLE: if (in_valid) begin
          cmd_r <= in_cmd;
          case (in_cmd)
            CMD_ADD_RES: begin
              state_r <= S_OUT;
              if (rcnt_r >= RCW'(MAX_RESOURCES)) begin
                st_r <= ST_FULL;
                id_r <= '0;
              end else begin
                st_r <= ST_OK;
                rcnt_r <= rcnt_r + RCW'(1);
                id_r <= ID_W'(rcnt_r) + ID_W'(1);
              end
            end
            CMD_ADD_PASS: begin
              state_r <= S_OUT;
              if (pcnt_r >= PCW'(MAX_PASSES)) begin
                st_r <= ST_FULL;
                id_r <= '0;
              end else begin
                st_r <= ST_OK;
                kind_r[pcnt_r[PW-1:0]] <= in_pass_type;
                neg_r[pcnt_r[PW-1:0]] <= in_mip[7];
                rdc_r[pcnt_r[PW-1:0]] <= '0;
                wrc_r[pcnt_r[PW-1:0]] <= '0;
                pcnt_r <= pcnt_r + PCW'(1);
                id_r <= ID_W'(pcnt_r) + ID_W'(1);
              end
            end
            CMD_ADD_READ, CMD_ADD_WRITE: begin
              pp_r <= PCW'(in_pass_id - 6'd1);
              rid_r <= in_resource_id;
              i_r <= '0;
              side_r <= 1'b0;
              id_r <= '0;
              if (in_pass_id == 6'd0 || 7'(in_pass_id) > 7'(pcnt_r) ||
                  in_resource_id == 7'd0 || 9'(in_resource_id) > 9'(rcnt_r)) begin
                st_r <= ST_REJECT;
                state_r <= S_OUT;
              end else begin
                st_r <= ST_OK;
                state_r <= S_REF_RD;
              end
            end
            CMD_SCHEDULE: begin
              r_r <= '0;
              st_r <= ST_OK;
              id_r <= '0;
              state_r <= S_V_RES;
            end
            CMD_CLEAR: begin
              rcnt_r <= '0;
              pcnt_r <= '0;
              st_r <= ST_OK;
              id_r <= '0;
              state_r <= S_OUT;
            end
            default: begin
              st_r <= ST_REJECT;
              id_r <= '0;
              state_r <= S_OUT;
            end
          endcase
        end
        S_REF_RD: begin
          if (i_r >= cur_cnt) begin
            if (side_r) begin
              if (tgt_cnt >= CW'(MAX_REFS)) st_r <= ST_FULL;
              else if (cmd_r == CMD_ADD_WRITE) wrc_r[pidx] <= wrc_r[pidx] + CW'(1);
              else rdc_r[pidx] <= rdc_r[pidx] + CW'(1);
              state_r <= S_OUT;
            end else begin
              side_r <= 1'b1;
              i_r <= '0;
            end
          end else state_r <= S_REF_CHK;
        end
        S_REF_CHK: begin
          if (ram_rd == rid_r) begin
            st_r <= ST_REJECT;
            state_r <= S_OUT;
          end else begin
            i_r <= i_r + CW'(1);
            state_r <= S_REF_RD;
          end
        end
        S_OUT: if (!ob_full) state_r <= S_IDLE;
        S_V_RES: begin
          if (r_r >= rcnt_r) begin
            wvalid_r <= '0;
            pp_r <= '0;
            state_r <= S_V_PASS;
          end else state_r <= S_V_RES_CHK;
        end
        S_V_RES_CHK: begin
          if (!rok_rd) begin
            st_r <= ST_BOUNDS;
            state_r <= S_OUT;
          end else begin
            r_r <= r_r + RCW'(1);
            state_r <= S_V_RES;
          end
        end
        S_V_PASS: begin
          if (pp_r >= pcnt_r) begin
            if (pcnt_r == '0) state_r <= S_OUT;
            else begin
              pp_r <= '0;
              side_r <= 1'b0;
              state_r <= S_P_INIT;
            end
          end else if (rule_st != ST_OK) begin
            st_r <= rule_st;
            state_r <= S_OUT;
          end else begin
            i_r <= '0;
            side_r <= 1'b1;
            state_r <= S_V_WR;
          end
        end
        S_V_WR: begin
          if (i_r >= wrc_r[pidx]) begin
            pp_r <= pp_r + PCW'(1);
            state_r <= S_V_PASS;
          end else state_r <= S_V_WR_CHK;
        end
        S_V_WR_CHK: begin
          if (wvalid_r[ram_slot]) begin
            st_r <= ST_MULTI_WRITER;
            state_r <= S_OUT;
          end else begin
            wvalid_r[ram_slot] <= 1'b1;
            i_r <= i_r + CW'(1);
            state_r <= S_V_WR;
          end
        end
        S_P_INIT: begin
          if (pp_r >= pcnt_r) begin
            done_r <= '0;
            emitted_r <= '0;
            state_r <= S_K_FIND;
          end else begin
            pend_r[pidx] <= '0;
            i_r <= '0;
            state_r <= S_P_RD;
          end
        end
        S_P_RD: begin
          if (i_r >= rdc_r[pidx]) begin
            pp_r <= pp_r + PCW'(1);
            state_r <= S_P_INIT;
          end else state_r <= S_P_CHK;
        end
        S_P_CHK: begin
          if (wvalid_r[ram_slot]) pend_r[pidx] <= pend_r[pidx] + CW'(1);
          i_r <= i_r + CW'(1);
          state_r <= S_P_RD;
        end
        S_K_FIND: begin
          if (find_ok) begin
            done_r[find_idx] <= 1'b1;
            cur_r <= find_idx;
            emitted_r <= emitted_r + PCW'(1);
            pp_r <= '0;
            state_r <= S_K_UPD;
          end else if (emitted_r != pcnt_r) begin
            st_r <= ST_CYCLE;
            state_r <= S_OUT;
          end else begin
            ei_r <= '0;
            state_r <= S_EMIT_RD;
          end
        end
        S_K_UPD: begin
          if (pp_r >= pcnt_r) state_r <= S_K_FIND;
          else if (done_r[pidx]) pp_r <= pp_r + PCW'(1);
          else begin
            i_r <= '0;
            state_r <= S_K_URD;
          end
        end
        S_K_URD: begin
          if (i_r >= rdc_r[pidx]) begin
            pp_r <= pp_r + PCW'(1);
            state_r <= S_K_UPD;
          end else state_r <= S_K_UWO;
        end
        S_K_UWO: state_r <= S_K_UCHK;
        S_K_UCHK: begin
          if (wvalid_r[ram_slot] && wo_rd == cur_r && pend_r[pidx] != '0)
            pend_r[pidx] <= pend_r[pidx] - CW'(1);
          i_r <= i_r + CW'(1);
          state_r <= S_K_URD;
        end
        S_EMIT_RD: state_r <= S_EMIT;
        S_EMIT: begin
          if (!ob_full) begin
            if (ei_r + PCW'(1) >= pcnt_r) state_r <= S_IDLE;
            else begin
              ei_r <= ei_r + PCW'(1);
              state_r <= S_EMIT_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("accepted while busy");
  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    pcnt_r <= PCW'(MAX_PASSES) && rcnt_r <= RCW'(MAX_RESOURCES)) else $error("count range");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
`endif
endmodule

[tb/tb.sv]
// Testbench for render_pass_dependency_scheduler_top: directed, table-full, random and backpressure tests.
// Commands are checked against a built-in predictor of the table and scheduling behavior.
// Depends on rpds_pkg and the DUT sources under hdl.
`timescale 1ns / 100ps

module tb;
  import rpds_pkg::*;

  localparam int N_RES = 64;
  localparam int N_PASS = 32;
  localparam int N_REFS = 8;
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;
  localparam int IDLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_cmd = '0;
  logic [5:0] in_pass_id = '0;
  logic [6:0] in_resource_id = '0;
  logic signed [15:0] in_width = '0;
  logic signed [15:0] in_height = '0;
  logic [2:0] in_pass_type = '0;
  logic signed [7:0] in_mip = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [3:0] out_status;
  logic [6:0] out_id;
  logic out_last;

  render_pass_dependency_scheduler_top DUT (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic       res_ok [N_RES];
  int         res_cnt, pass_cnt;
  logic [2:0] kind [N_PASS];
  logic       mip_neg [N_PASS];
  logic [6:0] rd_list [N_PASS][N_REFS];
  logic [6:0] wr_list [N_PASS][N_REFS];
  int         rd_cnt [N_PASS];
  int         wr_cnt [N_PASS];

  result_t expected_q[$];
  int errors = 0;
  int sent = 0;
  int results_seen = 0;
  int schedules_ok = 0;
  int in_idle_pct = 0;
  int out_stall_pct = 0;
  bit hold_out = 1'b0;

  function automatic void push_result(logic [3:0] st, int id, bit last);
    result_t r;
    r.status = st;
    r.id = id[6:0];
    r.last = last;
    expected_q = {expected_q, r};
  endfunction

  function automatic bit ref_listed(int p, int rid);
    for (int i = 0; i < rd_cnt[p]; i++) if (rd_list[p][i] == rid) return 1'b1;
    for (int i = 0; i < wr_cnt[p]; i++) if (wr_list[p][i] == rid) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [3:0] rule_status(ref int writer[N_RES]);
    int k, nr, nw, slot;
    for (int r = 0; r < res_cnt; r++) if (!res_ok[r]) return ST_BOUNDS;
    for (int r = 0; r < N_RES; r++) writer[r] = 0;
    for (int p = 0; p < pass_cnt; p++) begin
      k = kind[p];
      nr = rd_cnt[p];
      nw = wr_cnt[p];
      if (k == KIND_CLEAR && nr != 0) return ST_CLR_READS;
      if (k == KIND_CLEAR && nw == 0) return ST_CLR_NOWRITE;
      if (k == KIND_READBACK && nr == 0) return ST_RB_NOREAD;
      if (k == KIND_READBACK && nw != 0) return ST_RB_WRITES;
      if (mip_neg[p]) return ST_NEG_MIP;
      if (k > KIND_READBACK && (nr == 0 || nw == 0)) return ST_ORD_MISSING;
      for (int i = 0; i < nw; i++) begin
        slot = wr_list[p][i] - 1;
        if (writer[slot] != 0) return ST_MULTI_WRITER;
        writer[slot] = p + 1;
      end
    end
    return ST_OK;
  endfunction

  function automatic void predict_schedule();
    int writer [N_RES];
    int pending [N_PASS];
    bit done [N_PASS];
    int order [N_PASS];
    int n, cur, emitted, slot;
    logic [3:0] st;
    st = rule_status(writer);
    n = pass_cnt;
    emitted = 0;
    if (st != ST_OK) begin
      push_result(st, 0, 1'b1);
      return;
    end
    if (n == 0) begin
      push_result(ST_OK, 0, 1'b1);
      return;
    end
    for (int p = 0; p < n; p++) begin
      pending[p] = 0;
      done[p] = 1'b0;
      for (int i = 0; i < rd_cnt[p]; i++)
        if (writer[rd_list[p][i] - 1] != 0) pending[p]++;
    end
    forever begin
      cur = n;
      for (int p = 0; p < n; p++)
        if (!done[p] && pending[p] == 0) begin
          cur = p;
          break;
        end
      if (cur == n) break;
      done[cur] = 1'b1;
      order[emitted++] = cur + 1;
      for (int p = 0; p < n; p++) begin
        if (done[p]) continue;
        for (int i = 0; i < rd_cnt[p]; i++) begin
          slot = rd_list[p][i] - 1;
          if (writer[slot] == cur + 1 && pending[p] != 0) pending[p]--;
        end
      end
    end
    if (emitted != n) begin
      push_result(ST_CYCLE, 0, 1'b1);
      return;
    end
    schedules_ok++;
    for (int i = 0; i < n; i++) push_result(ST_OK, order[i], i + 1 == n);
  endfunction

  function automatic void predict_command(logic [2:0] cmd, logic [5:0] pid, logic [6:0] rid,
                                          logic signed [15:0] w, logic signed [15:0] h,
                                          logic [2:0] pt, logic signed [7:0] mip);
    int p;
    case (cmd)
      CMD_ADD_RES: begin
        if (res_cnt >= N_RES) push_result(ST_FULL, 0, 1'b1);
        else begin
          res_ok[res_cnt] = (w > 0) && (h > 0);
          res_cnt++;
          push_result(ST_OK, res_cnt, 1'b1);
        end
      end
      CMD_ADD_PASS: begin
        if (pass_cnt >= N_PASS) push_result(ST_FULL, 0, 1'b1);
        else begin
          kind[pass_cnt] = pt;
          mip_neg[pass_cnt] = mip[7];
          rd_cnt[pass_cnt] = 0;
          wr_cnt[pass_cnt] = 0;
          pass_cnt++;
          push_result(ST_OK, pass_cnt, 1'b1);
        end
      end
      CMD_ADD_READ, CMD_ADD_WRITE: begin
        if (pid == 0 || pid > pass_cnt || rid == 0 || rid > res_cnt)
          push_result(ST_REJECT, 0, 1'b1);
        else begin
          p = pid - 1;
          if (ref_listed(p, rid)) push_result(ST_REJECT, 0, 1'b1);
          else if (cmd == CMD_ADD_WRITE) begin
            if (wr_cnt[p] >= N_REFS) push_result(ST_FULL, 0, 1'b1);
            else begin
              wr_list[p][wr_cnt[p]++] = rid;
              push_result(ST_OK, 0, 1'b1);
            end
          end else begin
            if (rd_cnt[p] >= N_REFS) push_result(ST_FULL, 0, 1'b1);
            else begin
              rd_list[p][rd_cnt[p]++] = rid;
              push_result(ST_OK, 0, 1'b1);
            end
          end
        end
      end
      CMD_SCHEDULE: predict_schedule();
      CMD_CLEAR: begin
        res_cnt = 0;
        pass_cnt = 0;
        push_result(ST_OK, 0, 1'b1);
      end
      default: push_result(ST_REJECT, 0, 1'b1);
    endcase
  endfunction

  task automatic send_item(logic [2:0] cmd, logic [5:0] pid = 0, logic [6:0] rid = 0,
                           logic signed [15:0] w = 16, logic signed [15:0] h = 16,
                           logic [2:0] pt = 2, logic signed [7:0] mip = 0);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_cmd <= cmd;
    in_pass_id <= pid;
    in_resource_id <= rid;
    in_width <= w;
    in_height <= h;
    in_pass_type <= pt;
    in_mip <= mip;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_command(cmd, pid, rid, w, h, pt, mip);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= !hold_out && ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("unexpected transaction: status %0d id %0d last %0d", out_status, out_id,
               out_last);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_status !== e.status) begin
          $error("status: expected %0d actual %0d", e.status, out_status);
          errors++;
        end
        if (out_id !== e.id) begin
          $error("id: expected %0d actual %0d", e.id, out_id);
          errors++;
        end
        if (out_last !== e.last) begin
          $error("last: expected %0d actual %0d", e.last, out_last);
          errors++;
        end
      end
    end
  end

  int quiet = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= IDLE_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic test_directed();
    send_item(CMD_SCHEDULE);
    send_item(CMD_ADD_RES, 0, 0, 16'sh7FFF, 16'sh7FFF);
    send_item(CMD_ADD_RES, 0, 0, 1, 1);
    send_item(CMD_ADD_RES, 0, 0, 5, 5);
    send_item(CMD_ADD_PASS, 0, 0, 0, 0, KIND_CLEAR, 0);
    send_item(CMD_ADD_PASS, 0, 0, 0, 0, 3'd7, 8'sh7F);
    send_item(CMD_ADD_PASS, 0, 0, 0, 0, KIND_READBACK, 0);
    send_item(CMD_ADD_WRITE, 1, 1);
    send_item(CMD_ADD_READ, 2, 1);
    send_item(CMD_ADD_WRITE, 2, 2);
    send_item(CMD_ADD_READ, 3, 2);
    send_item(CMD_ADD_READ, 3, 2);
    send_item(CMD_ADD_READ, 0, 1);
    send_item(CMD_ADD_READ, 4, 1);
    send_item(CMD_ADD_WRITE, 1, 0);
    send_item(CMD_ADD_WRITE, 1, 7'd64);
    send_item(CMD_SCHEDULE);
    send_item(CMD_SPARE_A);
    send_item(CMD_SPARE_B);
    send_item(CMD_ADD_PASS, 0, 0, 0, 0, 3'd2, 8'sh80);
    send_item(CMD_SCHEDULE);
    send_item(CMD_ADD_RES, 0, 0, 16'sh8000, 0);
    send_item(CMD_SCHEDULE);
    send_item(CMD_CLEAR);
    send_item(CMD_SCHEDULE);
    drain();
  endtask

  task automatic test_table_full();
    send_item(CMD_CLEAR);
    for (int i = 0; i <= N_RES; i++) send_item(CMD_ADD_RES, 0, 0, 8, 8);
    for (int i = 0; i <= N_PASS; i++) send_item(CMD_ADD_PASS, 0, 0, 0, 0, 3'd2, 0);
    for (int i = 1; i <= N_REFS + 1; i++) send_item(CMD_ADD_READ, 6'd32, 7'(i));
    for (int i = 20; i <= 20 + N_REFS; i++) send_item(CMD_ADD_WRITE, 6'd32, 7'(i));
    send_item(CMD_SCHEDULE);
    drain();
  endtask

  task automatic random_graph();
    int np, nres;
    logic [2:0] pt;
    np = $urandom_range(1, 4);
    nres = np + 2;
    send_item(CMD_CLEAR);
    for (int r = 0; r < nres; r++)
      if ($urandom_range(19) == 0)
        send_item(CMD_ADD_RES, 0, 0, 16'($urandom), 16'($urandom));
      else
        send_item(CMD_ADD_RES, 0, 0, 16'($urandom_range(1, 32767)),
                  16'($urandom_range(1, 32767)));
    for (int p = 1; p <= np; p++) begin
      pt = 3'(($urandom_range(9) == 0) ? $urandom_range(1, 0) : $urandom_range(7, 2));
      send_item(CMD_ADD_PASS, 0, 0, 0, 0, pt,
                8'(($urandom_range(19) == 0) ? $urandom : $urandom_range(127)));
      if (pt != KIND_READBACK) send_item(CMD_ADD_WRITE, 6'(p), 7'(p));
      if (pt != KIND_CLEAR)
        repeat ($urandom_range(1, 2))
          send_item(CMD_ADD_READ, 6'(p), 7'($urandom_range(1, nres)));
      if ($urandom_range(7) == 0)
        send_item(3'($urandom_range(7)), 6'($urandom), 7'($urandom), 16'($urandom),
                  16'($urandom), 3'($urandom), 8'($urandom));
    end
    send_item(CMD_SCHEDULE);
  endtask

  task automatic test_random();
    int idle_tab [4] = '{0, 76, 0, 7};
    int stall_tab [4] = '{0, 0, 76, 7};
    for (int ph = 0; ph < 4; ph++) begin
      in_idle_pct = idle_tab[ph];
      out_stall_pct = stall_tab[ph];
      random_graph();
      drain();
    end
    in_idle_pct = 0;
    out_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_out = 1'b1;
        repeat (400) @(posedge clk);
        hold_out = 1'b0;
      end
      random_graph();
    join
    drain();
  endtask

  initial begin
    res_cnt = 0;
    pass_cnt = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_table_full();
    test_random();
    test_backpressure();
    $display("Sent %0d commands, checked %0d results, %0d successful schedules,",
             sent, results_seen, schedules_ok);
    $display("covering table limits, rule errors, cycles and handshake stalls.");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
